// File: rtl/mdc_pkg.sv
// Shared types and constants of the maze carver.
package mdc_pkg;

    localparam int CFG_W = 7;

    localparam logic [CFG_W-1:0] GRID_RESET = 7'd16;

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    localparam logic ACT_STEP    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    localparam logic [1:0] DIR_NORTH = 2'd0;
    localparam logic [1:0] DIR_SOUTH = 2'd1;
    localparam logic [1:0] DIR_EAST  = 2'd2;
    localparam logic [1:0] DIR_WEST  = 2'd3;

    typedef struct packed {
        logic       action;
        logic [1:0] random_dir;
    } in_beat_t;

    typedef struct packed {
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic [1:0] carve_dir;
        logic       carved;
        logic       finished;
    } out_beat_t;

endpackage

// File: rtl/maze_dfs_carver.sv
// Randomized depth-first maze carver: control, grid registers and result stage.
//
//   channel  | ports                              | moves
//   ---------+------------------------------------+------------------------------
//   input    | s_valid s_ready s_data             | one step or restart per beat
//   result   | m_valid m_ready m_data             | one result beat per input beat
//   config   | cfg_wr_en cfg_index cfg_wr_data    | grid width / height writes
//
// A search step runs through accept, three visited-map row reads (north, own,
// south row) through the single read port, evaluation, then the result stage. Each
// popped cell that leaves the stack non-empty adds a stack load, row reads and a
// new evaluation; a step once the maze is done goes straight to the result stage.
// A restart clears one map row per cycle. Reset is synchronous and clears control
// state only; restart clears the map. A stalled result beat holds in the output
// register while the next input beat is taken; that item waits at its result.
module maze_dfs_carver #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  mdc_pkg::in_beat_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output mdc_pkg::out_beat_t          m_data,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [mdc_pkg::CFG_W-1:0]   cfg_wr_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);
    localparam int EW    = 9;

    localparam logic [EW-1:0] MAXW_E = EW'(MAX_WIDTH);
    localparam logic [EW-1:0] MAXH_E = EW'(MAX_HEIGHT);
    localparam logic [NW-1:0] DEPTH_N = NW'(DEPTH);
    localparam logic [RW-1:0] LAST_ROW = RW'(MAX_HEIGHT - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_CHK0  = 4'd2;
    localparam logic [3:0] S_CHK1  = 4'd3;
    localparam logic [3:0] S_CHK2  = 4'd4;
    localparam logic [3:0] S_CHK3  = 4'd5;
    localparam logic [3:0] S_EVAL  = 4'd6;
    localparam logic [3:0] S_LOAD  = 4'd7;
    localparam logic [3:0] S_RESP  = 4'd8;

    logic [3:0]                 state_reg, state_next;
    logic [mdc_pkg::CFG_W-1:0]  grid_w_reg, grid_h_reg;
    logic                       done_reg, done_next;
    logic [NW-1:0]              count_reg, count_next;
    logic [CW-1:0]              top_x_reg, top_x_next;
    logic [RW-1:0]              top_y_reg, top_y_next;
    logic [1:0]                 dir_reg, dir_next;
    logic                       vis_n_reg, vis_s_reg, vis_e_reg, vis_w_reg;
    logic                       vis_n_next, vis_s_next, vis_e_next, vis_w_next;
    logic [RW-1:0]              clr_row_reg, clr_row_next;
    mdc_pkg::out_beat_t         res_reg, res_next;
    logic                       m_valid_reg, m_valid_next;
    mdc_pkg::out_beat_t         m_data_reg, m_data_next;

    logic [EW-1:0]              w_eff, h_eff;
    logic [3:0]                 in_grid, open_dir;
    logic                       carve;
    logic [CW-1:0]              x_e, x_w, nx;
    logic [RW-1:0]              y_n, y_s, ny;
    logic                       out_free;

    logic                       vis_row_we, vis_bit_we;
    logic [RW-1:0]              vis_wr_addr, vis_rd_addr;
    logic [CW-1:0]              vis_wr_col;
    logic [MAX_WIDTH-1:0]       vis_wr_row, vis_rd_data;
    logic                       stk_we;
    logic [AW-1:0]              stk_wr_addr, stk_rd_addr;
    logic [RW+CW-1:0]           stk_wr_data, stk_rd_data;

    mdc_visited_ram #(
        .ROWS(MAX_HEIGHT), .COLS(MAX_WIDTH), .RW(RW), .CW(CW)
    ) u_visited (
        .aclk       (aclk),
        .wr_row_en  (vis_row_we),
        .wr_bit_en  (vis_bit_we),
        .wr_addr    (vis_wr_addr),
        .wr_col     (vis_wr_col),
        .wr_row_data(vis_wr_row),
        .rd_addr    (vis_rd_addr),
        .rd_data    (vis_rd_data)
    );

    mdc_stack_ram #(
        .DEPTH(DEPTH), .AW(AW), .DW(RW + CW)
    ) u_stack (
        .aclk   (aclk),
        .wr_en  (stk_we),
        .wr_addr(stk_wr_addr),
        .wr_data(stk_wr_data),
        .rd_addr(stk_rd_addr),
        .rd_data(stk_rd_data)
    );

    // effective grid size: zero acts as one, large values saturate
    always_comb begin
        if (grid_w_reg == '0) begin
            w_eff = EW'(1);
        end else if (EW'(grid_w_reg) > MAXW_E) begin
            w_eff = MAXW_E;
        end else begin
            w_eff = EW'(grid_w_reg);
        end
        if (grid_h_reg == '0) begin
            h_eff = EW'(1);
        end else if (EW'(grid_h_reg) > MAXH_E) begin
            h_eff = MAXH_E;
        end else begin
            h_eff = EW'(grid_h_reg);
        end
    end

    assign x_e = top_x_reg + CW'(1);
    assign x_w = top_x_reg - CW'(1);
    assign y_n = top_y_reg - RW'(1);
    assign y_s = top_y_reg + RW'(1);

    // stacked cells may lie outside a shrunken grid, so check every side
    always_comb begin
        in_grid = '0;
        in_grid[mdc_pkg::DIR_NORTH] = (top_y_reg != '0) && ((EW'(top_y_reg) - EW'(1)) < h_eff)
                                      && (EW'(top_x_reg) < w_eff);
        in_grid[mdc_pkg::DIR_SOUTH] = ((EW'(top_y_reg) + EW'(1)) < h_eff)
                                      && (EW'(top_x_reg) < w_eff);
        in_grid[mdc_pkg::DIR_EAST]  = ((EW'(top_x_reg) + EW'(1)) < w_eff)
                                      && (EW'(top_y_reg) < h_eff);
        in_grid[mdc_pkg::DIR_WEST]  = (top_x_reg != '0) && ((EW'(top_x_reg) - EW'(1)) < w_eff)
                                      && (EW'(top_y_reg) < h_eff);
        open_dir = '0;
        open_dir[mdc_pkg::DIR_NORTH] = in_grid[mdc_pkg::DIR_NORTH] && !vis_n_reg;
        open_dir[mdc_pkg::DIR_SOUTH] = in_grid[mdc_pkg::DIR_SOUTH] && !vis_s_reg;
        open_dir[mdc_pkg::DIR_EAST]  = in_grid[mdc_pkg::DIR_EAST]  && !vis_e_reg;
        open_dir[mdc_pkg::DIR_WEST]  = in_grid[mdc_pkg::DIR_WEST]  && !vis_w_reg;
    end

    always_comb begin
        case (dir_reg)
            mdc_pkg::DIR_NORTH: begin
                nx = top_x_reg;
                ny = y_n;
            end
            mdc_pkg::DIR_SOUTH: begin
                nx = top_x_reg;
                ny = y_s;
            end
            mdc_pkg::DIR_EAST: begin
                nx = x_e;
                ny = top_y_reg;
            end
            default: begin
                nx = x_w;
                ny = top_y_reg;
            end
        endcase
    end

    assign carve    = (state_reg == S_EVAL) && (open_dir != '0) && (count_reg < DEPTH_N)
                      && open_dir[dir_reg];
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = aresetn && (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        done_next    = done_reg;
        count_next   = count_reg;
        top_x_next   = top_x_reg;
        top_y_next   = top_y_reg;
        dir_next     = dir_reg;
        vis_n_next   = vis_n_reg;
        vis_s_next   = vis_s_reg;
        vis_e_next   = vis_e_reg;
        vis_w_next   = vis_w_reg;
        clr_row_next = clr_row_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        vis_row_we  = 1'b0;
        vis_bit_we  = 1'b0;
        vis_wr_addr = clr_row_reg;
        vis_wr_col  = nx;
        vis_wr_row  = '0;
        vis_rd_addr = top_y_reg;
        stk_we      = 1'b0;
        stk_wr_addr = count_reg[AW-1:0];
        stk_wr_data = {ny, nx};
        stk_rd_addr = AW'(count_reg - NW'(2));

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    dir_next = s_data.random_dir;
                    res_next = '0;
                    if (s_data.action == mdc_pkg::ACT_RESTART) begin
                        count_next   = NW'(1);
                        top_x_next   = '0;
                        top_y_next   = '0;
                        done_next    = 1'b0;
                        clr_row_next = '0;
                        stk_we       = 1'b1;
                        stk_wr_addr  = '0;
                        stk_wr_data  = '0;
                        state_next   = S_CLEAR;
                    end else if (done_reg) begin
                        res_next.finished = 1'b1;
                        state_next        = S_RESP;
                    end else begin
                        state_next = S_CHK0;
                    end
                end
            end
            S_CLEAR: begin
                // cell (0,0) starts out visited
                vis_row_we   = 1'b1;
                vis_wr_row   = (clr_row_reg == '0) ? MAX_WIDTH'(1) : '0;
                clr_row_next = clr_row_reg + RW'(1);
                if (clr_row_reg == LAST_ROW) begin
                    state_next = S_RESP;
                end
            end
            S_CHK0: begin
                vis_rd_addr = y_n;
                state_next  = S_CHK1;
            end
            S_CHK1: begin
                vis_rd_addr = top_y_reg;
                vis_n_next  = vis_rd_data[top_x_reg];
                state_next  = S_CHK2;
            end
            S_CHK2: begin
                vis_rd_addr = y_s;
                vis_e_next  = vis_rd_data[x_e];
                vis_w_next  = vis_rd_data[x_w];
                state_next  = S_CHK3;
            end
            S_CHK3: begin
                vis_s_next = vis_rd_data[top_x_reg];
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (open_dir == '0) begin
                    // dead end: pop and re-check the new top, or finish once the stack is empty
                    count_next = count_reg - NW'(1);
                    if (count_reg == NW'(1)) begin
                        done_next         = 1'b1;
                        res_next.finished = 1'b1;
                        state_next        = S_RESP;
                    end else begin
                        state_next = S_LOAD;
                    end
                end else begin
                    if (carve) begin
                        vis_bit_we         = 1'b1;
                        vis_wr_addr        = ny;
                        stk_we             = 1'b1;
                        count_next         = count_reg + NW'(1);
                        top_x_next         = nx;
                        top_y_next         = ny;
                        res_next.cell_x    = 6'(top_x_reg);
                        res_next.cell_y    = 6'(top_y_reg);
                        res_next.carve_dir = dir_reg;
                        res_next.carved    = 1'b1;
                    end
                    state_next = S_RESP;
                end
            end
            S_LOAD: begin
                {top_y_next, top_x_next} = stk_rd_data;
                state_next               = S_CHK0;
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            grid_w_reg  <= mdc_pkg::GRID_RESET;
            grid_h_reg  <= mdc_pkg::GRID_RESET;
            done_reg    <= 1'b1;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                if (cfg_index == mdc_pkg::REG_GRID_WIDTH) begin
                    grid_w_reg <= cfg_wr_data;
                end else begin
                    grid_h_reg <= cfg_wr_data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        top_x_reg   <= top_x_next;
        top_y_reg   <= top_y_next;
        dir_reg     <= dir_next;
        vis_n_reg   <= vis_n_next;
        vis_s_reg   <= vis_s_next;
        vis_e_reg   <= vis_e_next;
        vis_w_reg   <= vis_w_next;
        clr_row_reg <= clr_row_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

    a_live_stack: assert property (@(posedge aclk) disable iff (!aresetn)
        !done_reg |-> count_reg != '0)
        else $error("search active with empty stack");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_N)
        else $error("stack count above depth");

    a_push: assert property (@(posedge aclk) disable iff (!aresetn)
        carve |=> count_reg == $past(count_reg) + NW'(1) && res_reg.carved)
        else $error("carve did not push");

    a_pop_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EVAL && open_dir == '0 && count_reg == NW'(1))
        |=> done_reg && res_reg.finished)
        else $error("last pop did not finish search");

endmodule

// File: rtl/mdc_visited_ram.sv
// Visited map: one row of cell bits per word, row write or single bit set.
module mdc_visited_ram #(
    parameter int ROWS = 64,
    parameter int COLS = 64,
    parameter int RW   = 6,
    parameter int CW   = 6
) (
    input  logic            aclk,
    input  logic            wr_row_en,
    input  logic            wr_bit_en,
    input  logic [RW-1:0]   wr_addr,
    input  logic [CW-1:0]   wr_col,
    input  logic [COLS-1:0] wr_row_data,
    input  logic [RW-1:0]   rd_addr,
    output logic [COLS-1:0] rd_data
);

    logic [COLS-1:0] mem [ROWS];

    always_ff @(posedge aclk) begin
        if (wr_row_en) begin
            mem[wr_addr] <= wr_row_data;
        end else if (wr_bit_en) begin
            mem[wr_addr][wr_col] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/mdc_stack_ram.sv
// Path stack storage: one write and one registered read per cycle.
module mdc_stack_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 12
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
